[rtl/core/sctile_pkg.sv]
// Shared types and constants for the sparse chunked tile store.
// No dependencies; used by sctile_decode and sparse_chunked_tile_store_top.
package sctile_pkg;

  localparam int SHIFT_W  = 3;
  localparam int SPAN_W   = 5;
  localparam int VAL_W    = 8;
  localparam int STATUS_W = 2;
  localparam int CIDX_W   = 2 * SPAN_W;

  localparam logic [SHIFT_W-1:0] SHIFT_RST    = 3'd4;
  localparam logic [SPAN_W-1:0]  ACROSS_RST   = 5'd16;
  localparam logic [SPAN_W-1:0]  DOWN_RST     = 5'd16;
  localparam logic [VAL_W-1:0]   BLOCKING_RST = 8'd1;

  typedef enum logic [1:0] {
    CFG_CHUNK_SHIFT    = 2'd0,
    CFG_CHUNKS_ACROSS  = 2'd1,
    CFG_CHUNKS_DOWN    = 2'd2,
    CFG_BLOCKING_VALUE = 2'd3
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_POOL_FULL = 2'd2
  } status_t;

endpackage

[rtl/core/sparse_chunked_tile_store_top.sv]
// Sparse chunked tile store: chunk table and tile memory with slot allocation.
// Depends on sctile_pkg and sctile_decode.
// done rises after the request passes S_LOOK (chunk-table read) and S_ACCESS (tile read).
// A new start is taken in the done cycle; busy holds off new starts in S_LOOK and S_ACCESS.
// Reset: a clearing pass over max(POOL_SLOTS * 4**MAX_CHUNK_SHIFT, MAX_CHUNKS) entries
// (16384 by default) holds busy high; results cannot be stalled by the receiver.
module sparse_chunked_tile_store_top #(
  parameter int MAX_CHUNKS      = 256,
  parameter int POOL_SLOTS      = 64,
  parameter int MAX_CHUNK_SHIFT = 4,
  parameter int COORD_BITS      = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type,
  input  logic [COORD_BITS-1:0]            tile_row,
  input  logic [COORD_BITS-1:0]            tile_col,
  input  logic [sctile_pkg::VAL_W-1:0]     write_value,
  output logic                             done,
  output logic [sctile_pkg::VAL_W-1:0]     read_value,
  output logic                             accessible,
  output logic [sctile_pkg::STATUS_W-1:0]  status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [sctile_pkg::VAL_W-1:0]     cfg_data
);

  localparam int OFF_W      = 2 * MAX_CHUNK_SHIFT;
  localparam int SLOT_TILES = 1 << OFF_W;
  localparam int TILE_WORDS = POOL_SLOTS * SLOT_TILES;
  localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int FREE_W     = $clog2(POOL_SLOTS + 1);
  localparam int CHUNK_AW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int TILE_AW    = SLOT_W + OFF_W;
  localparam int CLR_LEN    = (TILE_WORDS > MAX_CHUNKS) ? TILE_WORDS : MAX_CHUNKS;
  localparam int CLR_W      = (TILE_AW > CHUNK_AW) ? TILE_AW : CHUNK_AW;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_LOOK   = 5'b00100,
    S_ACCESS = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [sctile_pkg::SHIFT_W-1:0] chunk_shift;
  logic [sctile_pkg::SPAN_W-1:0]  chunks_across;
  logic [sctile_pkg::SPAN_W-1:0]  chunks_down;
  logic [sctile_pkg::VAL_W-1:0]   blocking_value;

  logic [CLR_W-1:0]  clear_cnt;
  logic [FREE_W-1:0] next_free;

  logic                         req_read;
  logic [COORD_BITS-1:0]        row_q;
  logic [COORD_BITS-1:0]        col_q;
  logic [sctile_pkg::VAL_W-1:0] wval_q;

  logic                         dec_outside;
  logic [sctile_pkg::CIDX_W-1:0] dec_cidx;
  logic [OFF_W-1:0]             dec_offset;

  logic                  outside_q;
  logic [CHUNK_AW-1:0]   cidx_q;
  logic [OFF_W-1:0]      offset_q;

  logic [SLOT_W:0]       chunk_mem [MAX_CHUNKS];
  logic [SLOT_W:0]       chunk_rd;
  logic                  chunk_we;
  logic [CHUNK_AW-1:0]   chunk_waddr;
  logic [CHUNK_AW-1:0]   chunk_raddr;
  logic [SLOT_W:0]       chunk_wdata;

  logic [sctile_pkg::VAL_W-1:0] tile_mem [TILE_WORDS];
  logic [sctile_pkg::VAL_W-1:0] tile_rd;
  logic                         tile_we;
  logic [TILE_AW-1:0]           tile_addr;
  logic [sctile_pkg::VAL_W-1:0] tile_wdata;

  logic                  present;
  logic                  need_alloc;
  logic                  pool_full;
  logic                  alloc;
  logic [SLOT_W-1:0]     slot;
  logic                  clear_last;
  logic                  accept;

  sctile_pkg::status_t          status_q, status_next;
  logic                         rd_ok, rd_ok_next;
  logic [sctile_pkg::VAL_W-1:0] rd_val;

  sctile_decode #(
    .MAX_CHUNKS      (MAX_CHUNKS),
    .MAX_CHUNK_SHIFT (MAX_CHUNK_SHIFT),
    .COORD_BITS      (COORD_BITS)
  ) u_decode (
    .row           (row_q),
    .col           (col_q),
    .chunk_shift   (chunk_shift),
    .chunks_across (chunks_across),
    .chunks_down   (chunks_down),
    .outside       (dec_outside),
    .cidx          (dec_cidx),
    .offset        (dec_offset)
  );

  assign busy      = !(state == S_IDLE || state == S_REPLY);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign clear_last = (clear_cnt == CLR_W'(CLR_LEN - 1));

  always_comb begin
    present     = chunk_rd[SLOT_W];
    need_alloc  = !req_read && !outside_q && !present;
    pool_full   = next_free >= FREE_W'(POOL_SLOTS);
    alloc       = (state == S_ACCESS) && need_alloc && !pool_full;
    slot        = present ? chunk_rd[SLOT_W-1:0] : next_free[SLOT_W-1:0];
    rd_ok_next  = req_read && !outside_q && present;
    if (outside_q) begin
      status_next = sctile_pkg::ST_OUTSIDE;
    end else if (need_alloc && pool_full) begin
      status_next = sctile_pkg::ST_POOL_FULL;
    end else begin
      status_next = sctile_pkg::ST_OK;
    end

    chunk_raddr = CHUNK_AW'(dec_cidx);
    if (state == S_CLEAR) begin
      chunk_we    = 32'(clear_cnt) < 32'(MAX_CHUNKS);
      chunk_waddr = clear_cnt[CHUNK_AW-1:0];
      chunk_wdata = '0;
      tile_we     = 32'(clear_cnt) < 32'(TILE_WORDS);
      tile_addr   = clear_cnt[TILE_AW-1:0];
      tile_wdata  = '0;
    end else begin
      chunk_we    = alloc;
      chunk_waddr = cidx_q;
      chunk_wdata = {1'b1, next_free[SLOT_W-1:0]};
      tile_we     = (state == S_ACCESS) && !req_read && !outside_q && (present || !pool_full);
      tile_addr   = {slot, offset_q};
      tile_wdata  = wval_q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  state_next = clear_last ? S_IDLE : S_CLEAR;
      S_IDLE:   state_next = start ? S_LOOK : S_IDLE;
      S_LOOK:   state_next = S_ACCESS;
      S_ACCESS: state_next = S_REPLY;
      S_REPLY:  state_next = start ? S_LOOK : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clear_cnt      <= '0;
      next_free      <= '0;
      chunk_shift    <= sctile_pkg::SHIFT_RST;
      chunks_across  <= sctile_pkg::ACROSS_RST;
      chunks_down    <= sctile_pkg::DOWN_RST;
      blocking_value <= sctile_pkg::BLOCKING_RST;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (alloc) begin
        next_free <= next_free + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (sctile_pkg::cfg_idx_t'(cfg_index))
          sctile_pkg::CFG_CHUNK_SHIFT:    chunk_shift    <= cfg_data[sctile_pkg::SHIFT_W-1:0];
          sctile_pkg::CFG_CHUNKS_ACROSS:  chunks_across  <= cfg_data[sctile_pkg::SPAN_W-1:0];
          sctile_pkg::CFG_CHUNKS_DOWN:    chunks_down    <= cfg_data[sctile_pkg::SPAN_W-1:0];
          sctile_pkg::CFG_BLOCKING_VALUE: blocking_value <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_read <= req_type;
      row_q    <= tile_row;
      col_q    <= tile_col;
      wval_q   <= write_value;
    end
    if (state == S_LOOK) begin
      outside_q <= dec_outside;
      cidx_q    <= CHUNK_AW'(dec_cidx);
      offset_q  <= dec_offset;
    end
    if (state == S_ACCESS) begin
      status_q <= status_next;
      rd_ok    <= rd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (chunk_we) begin
      chunk_mem[chunk_waddr] <= chunk_wdata;
    end
    chunk_rd <= chunk_mem[chunk_raddr];
  end

  always_ff @(posedge clk) begin
    if (tile_we) begin
      tile_mem[tile_addr] <= tile_wdata;
    end
    tile_rd <= tile_mem[tile_addr];
  end

  assign rd_val     = rd_ok ? tile_rd : '0;
  assign done       = (state == S_REPLY);
  assign read_value = rd_val;
  assign accessible = (rd_val != '0) && (rd_val != blocking_value);
  assign status     = status_q;

  a_done_after_access: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_ACCESS))
    else $error("result without a preceding memory access");

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted request gave no result after three cycles");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_free) <= 32'(POOL_SLOTS))
    else $error("slot pool counter beyond pool size");

  a_accessible_ok: assert property (@(posedge clk) disable iff (rst)
    done && accessible |-> status == sctile_pkg::ST_OK && read_value != '0)
    else $error("accessible flag on a result that is not a good read");

endmodule

[rtl/core/sctile_decode.sv]
// Coordinate decode: chunk index, in-chunk tile offset and map bounds check.
// Depends on sctile_pkg.
module sctile_decode #(
  parameter int MAX_CHUNKS      = 256,
  parameter int MAX_CHUNK_SHIFT = 4,
  parameter int COORD_BITS      = 12
) (
  input  logic [COORD_BITS-1:0]           row,
  input  logic [COORD_BITS-1:0]           col,
  input  logic [sctile_pkg::SHIFT_W-1:0]  chunk_shift,
  input  logic [sctile_pkg::SPAN_W-1:0]   chunks_across,
  input  logic [sctile_pkg::SPAN_W-1:0]   chunks_down,
  output logic                            outside,
  output logic [sctile_pkg::CIDX_W-1:0]   cidx,
  output logic [2*MAX_CHUNK_SHIFT-1:0]    offset
);

  localparam int OFF_W = 2 * MAX_CHUNK_SHIFT;
  localparam int CMP_W = COORD_BITS + 1;

  logic [sctile_pkg::SHIFT_W-1:0] sh;
  logic [COORD_BITS-1:0]          crow;
  logic [COORD_BITS-1:0]          ccol;
  logic [OFF_W-1:0]               lowmask;
  logic [OFF_W-1:0]               row_lo;
  logic [OFF_W-1:0]               col_lo;
  logic                           row_out;
  logic                           col_out;
  logic                           idx_out;

  always_comb begin
    sh = (chunk_shift > sctile_pkg::SHIFT_W'(MAX_CHUNK_SHIFT)) ?
         sctile_pkg::SHIFT_W'(MAX_CHUNK_SHIFT) : chunk_shift;
    crow    = row >> sh;
    ccol    = col >> sh;
    row_out = CMP_W'(crow) >= CMP_W'(chunks_down);
    col_out = CMP_W'(ccol) >= CMP_W'(chunks_across);
    cidx    = sctile_pkg::CIDX_W'(crow) * sctile_pkg::CIDX_W'(chunks_across)
              + sctile_pkg::CIDX_W'(ccol);
    idx_out = 32'(cidx) >= 32'(MAX_CHUNKS);
    outside = row_out | col_out | idx_out;
    lowmask = ~({OFF_W{1'b1}} << sh);
    row_lo  = OFF_W'(row) & lowmask;
    col_lo  = OFF_W'(col) & lowmask;
    offset  = (row_lo << sh) + col_lo;
  end

endmodule
